// ===== hdl/rmq_pkg.sv =====
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Branch codes of Shepperd's method.
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

endpackage

// ===== hdl/rotation_matrix_to_quaternion_unit.sv =====
// Pipeline: the entry and radicand stages, then the bit-per-stage root and divider
// pipelines and the output register (default format Q2.14).
// Throughput: one transfer per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage.
// Reset: aresetn clears all valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // m11, m12, m13, m21, m22, m23, m31, m32, m33 from the lowest bit up
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // qw, qx, qy, qz, bad_radicand from the lowest bit up
    output logic [((4*DATA_WIDTH+8)/8)*8-1:0] m_tdata
);

    localparam int W     = DATA_WIDTH;
    localparam int RADW  = W + 3;                 // radicand, signed
    localparam int SQIN  = RADW - 1 + FRAC_BITS;  // positive radicand scaled
    localparam int RTW   = (SQIN + 1) / 2;        // root width
    localparam int SW    = RTW + 1;               // S = 2*root
    localparam int NUMW  = W + 1 + FRAC_BITS;     // |num| scaled
    localparam int TAGW  = 3 * (W + 1) + 3;       // 3 numerators, branch, bad
    localparam int OUTW  = ((4*W+8)/8)*8;

    logic en;
    logic out_vld_reg;
    logic [OUTW-1:0] out_data_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Stage 1: register entries and form trace and branch choice.
    logic signed [W-1:0] m [0:8];
    for (genvar i = 0; i < 9; i++) begin : g_unpack
        assign m[i] = $signed(s_tdata[i*W +: W]);
    end

    logic                 v1_reg;
    logic signed [W+1:0]  tr1_reg;
    logic [1:0]           br1_reg;
    logic signed [W-1:0]  e1_reg [0:8];

    logic signed [W+1:0] tr_next;
    logic [1:0]          br_next;
    always_comb begin
        tr_next = (W+2)'(m[0]) + (W+2)'(m[4]) + (W+2)'(m[8]);
        if (tr_next > 0) begin
            br_next = rmq_pkg::BR_TRACE;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            br_next = rmq_pkg::BR_X;
        end else if (m[4] > m[8]) begin
            br_next = rmq_pkg::BR_Y;
        end else begin
            br_next = rmq_pkg::BR_Z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tr1_reg <= tr_next;
            br1_reg <= br_next;
            for (int i = 0; i < 9; i++) begin
                e1_reg[i] <= m[i];
            end
        end
    end

    // Stage 2: radicand and the three numerators in output order.
    logic                 v2_reg;
    logic signed [RADW-1:0] r2_reg;
    logic [1:0]           br2_reg;
    logic signed [W:0]    n2_reg [0:2];

    logic signed [RADW-1:0] r_next;
    logic signed [W:0]      d32, d13, d21, s12, s13, s23;
    logic signed [W:0]      n_next [0:2];
    localparam logic signed [RADW-1:0] ONE = RADW'(1) <<< FRAC_BITS;
    always_comb begin
        d32 = (W+1)'(e1_reg[7]) - (W+1)'(e1_reg[5]);
        d13 = (W+1)'(e1_reg[2]) - (W+1)'(e1_reg[6]);
        d21 = (W+1)'(e1_reg[3]) - (W+1)'(e1_reg[1]);
        s12 = (W+1)'(e1_reg[1]) + (W+1)'(e1_reg[3]);
        s13 = (W+1)'(e1_reg[2]) + (W+1)'(e1_reg[6]);
        s23 = (W+1)'(e1_reg[5]) + (W+1)'(e1_reg[7]);
        case (br1_reg)
            rmq_pkg::BR_TRACE: begin
                r_next = ONE + RADW'(tr1_reg);
                n_next[0] = d32; n_next[1] = d13; n_next[2] = d21;
            end
            rmq_pkg::BR_X: begin
                r_next = ONE + RADW'(e1_reg[0]) - RADW'(e1_reg[4]) - RADW'(e1_reg[8]);
                n_next[0] = d32; n_next[1] = s12; n_next[2] = s13;
            end
            rmq_pkg::BR_Y: begin
                r_next = ONE + RADW'(e1_reg[4]) - RADW'(e1_reg[0]) - RADW'(e1_reg[8]);
                n_next[0] = d13; n_next[1] = s12; n_next[2] = s23;
            end
            default: begin
                r_next = ONE + RADW'(e1_reg[8]) - RADW'(e1_reg[0]) - RADW'(e1_reg[4]);
                n_next[0] = d21; n_next[1] = s13; n_next[2] = s23;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg  <= r_next;
            br2_reg <= br1_reg;
            for (int i = 0; i < 3; i++) begin
                n2_reg[i] <= n_next[i];
            end
        end
    end

    // Square root of the scaled radicand; numerators ride along as tag.
    logic            bad2;
    logic [SQIN-1:0] sq_in;
    logic [TAGW-1:0] sq_tag_in, sq_tag_out;
    logic            sq_vld;
    logic [RTW-1:0]  root;
    assign bad2  = (r2_reg <= 0);
    assign sq_in = bad2 ? '0 : (SQIN'(r2_reg[RADW-2:0]) << FRAC_BITS);
    assign sq_tag_in = {bad2, br2_reg, n2_reg[2], n2_reg[1], n2_reg[0]};

    rmq_sqrt #(.IN_W(SQIN), .OUT_W(RTW), .TAG_W(TAGW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v2_reg), .in_rad(sq_in), .in_tag(sq_tag_in),
        .out_valid(sq_vld), .out_root(root), .out_tag(sq_tag_out)
    );

    // Three dividers in parallel; the root (S/2) and flags travel in the tag.
    logic [SW-1:0] den;
    assign den = (root == '0) ? SW'(1) : {root, 1'b0};

    localparam int DTAG = RTW + 3;
    logic [DTAG-1:0] dv_tag_in;
    assign dv_tag_in = {sq_tag_out[TAGW-1 -: 3], root};

    logic signed [NUMW:0] quo [0:2];
    logic [DTAG-1:0]      dv_tag [0:2];
    logic                 dv_vld [0:2];
    for (genvar i = 0; i < 3; i++) begin : g_div
        logic signed [W:0] n;
        logic [W:0]        mag_n;
        logic [NUMW-1:0]   mag;
        assign n     = $signed(sq_tag_out[i*(W+1) +: (W+1)]);
        // The magnitude of the most negative numerator still fits unsigned.
        assign mag_n = n[W] ? (W+1)'(-n) : (W+1)'(n);
        assign mag   = NUMW'(mag_n) << FRAC_BITS;
        rmq_div #(.NUM_W(NUMW), .DEN_W(SW), .TAG_W(DTAG)) u_div (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(sq_vld), .in_mag(mag), .in_neg(n[W]), .in_den(den),
            .in_tag(dv_tag_in),
            .out_valid(dv_vld[i]), .out_quo(quo[i]), .out_tag(dv_tag[i])
        );
    end

    // Output stage: place components, saturate, zero on a bad radicand, register.
    localparam logic signed [NUMW:0] HI = (NUMW+1)'((64'sd1 <<< (W-1)) - 1);
    localparam logic signed [NUMW:0] LO = -HI - 1;
    function automatic logic [W-1:0] sat(input logic signed [NUMW:0] v);
        logic [W-1:0] r;
        if (v > HI) r = HI[W-1:0];
        else if (v < LO) r = LO[W-1:0];
        else r = v[W-1:0];
        return r;
    endfunction

    logic               bad_o;
    logic [1:0]         br_o;
    logic [RTW-1:0]     root_o;
    logic signed [NUMW:0] main_c;
    logic [W-1:0]       q [0:3];
    always_comb begin
        bad_o  = dv_tag[0][DTAG-1];
        br_o   = dv_tag[0][DTAG-2 -: 2];
        root_o = dv_tag[0][RTW-1:0];
        main_c = (NUMW+1)'(root_o >> 1);
        case (br_o)
            rmq_pkg::BR_TRACE: begin
                q[0] = sat(main_c); q[1] = sat(quo[0]);
                q[2] = sat(quo[1]); q[3] = sat(quo[2]);
            end
            rmq_pkg::BR_X: begin
                q[0] = sat(quo[0]); q[1] = sat(main_c);
                q[2] = sat(quo[1]); q[3] = sat(quo[2]);
            end
            rmq_pkg::BR_Y: begin
                q[0] = sat(quo[0]); q[1] = sat(quo[1]);
                q[2] = sat(main_c); q[3] = sat(quo[2]);
            end
            default: begin
                q[0] = sat(quo[0]); q[1] = sat(quo[1]);
                q[2] = sat(quo[2]); q[3] = sat(main_c);
            end
        endcase
        if (bad_o) begin
            for (int i = 0; i < 4; i++) q[i] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_vld[0] && dv_vld[1] && dv_vld[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= OUTW'({bad_o, q[3], q[2], q[1], q[0]});
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hdl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt #(
    parameter int IN_W  = 32,
    parameter int OUT_W = 16,
    parameter int TAG_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_rad,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [OUT_W-1:0]  out_root,
    output logic [TAG_W-1:0]  out_tag
);

    localparam int RW = 2 * OUT_W;

    logic [RW-1:0]    rem_reg  [0:OUT_W];
    logic [OUT_W-1:0] root_reg [0:OUT_W];
    logic [RW-1:0]    val_reg  [0:OUT_W];
    logic [TAG_W-1:0] tag_reg  [0:OUT_W];
    logic             vld_reg  [0:OUT_W];

    // Stage zero loads the operand.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            val_reg[0]  <= RW'(in_rad);
            tag_reg[0]  <= in_tag;
        end
    end

    // Each stage brings down two bits and decides one root bit.
    for (genvar g = 0; g < OUT_W; g++) begin : g_stage
        logic [RW+1:0] trial;
        logic [RW+1:0] rem_sh;
        always_comb begin
            rem_sh = {rem_reg[g], val_reg[g][RW-1 -: 2]};
            trial  = (RW+2)'({root_reg[g], 2'b01});
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_sh >= trial) begin
                    rem_reg[g+1]  <= RW'(rem_sh - trial);
                    root_reg[g+1] <= {root_reg[g][OUT_W-2:0], 1'b1};
                end else begin
                    rem_reg[g+1]  <= RW'(rem_sh);
                    root_reg[g+1] <= {root_reg[g][OUT_W-2:0], 1'b0};
                end
                val_reg[g+1] <= {val_reg[g][RW-3:0], 2'b00};
                tag_reg[g+1] <= tag_reg[g];
            end
        end
    end

    assign out_valid = vld_reg[OUT_W];
    assign out_root  = root_reg[OUT_W];
    assign out_tag   = tag_reg[OUT_W];

endmodule

// ===== hdl/rmq_div.sv =====
// Pipelined restoring divider for a signed numerator, one quotient bit per stage.
module rmq_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int TAG_W = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [NUM_W-1:0]        in_mag,
    input  logic                    in_neg,
    input  logic [DEN_W-1:0]        in_den,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic signed [NUM_W:0]   out_quo,
    output logic [TAG_W-1:0]        out_tag
);

    logic [DEN_W:0]   rem_reg [0:NUM_W];
    logic [NUM_W-1:0] quo_reg [0:NUM_W];
    logic [DEN_W-1:0] den_reg [0:NUM_W];
    logic             neg_reg [0:NUM_W];
    logic [TAG_W-1:0] tag_reg [0:NUM_W];
    logic             vld_reg [0:NUM_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            quo_reg[0] <= in_mag;
            den_reg[0] <= in_den;
            neg_reg[0] <= in_neg;
            tag_reg[0] <= in_tag;
        end
    end

    // Each stage shifts in one numerator bit and tries one subtraction.
    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [DEN_W+1:0] rem_sh;
        always_comb begin
            rem_sh = {rem_reg[g], quo_reg[g][NUM_W-1]};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_sh >= {2'b00, den_reg[g]}) begin
                    rem_reg[g+1] <= (DEN_W+1)'(rem_sh - {2'b00, den_reg[g]});
                    quo_reg[g+1] <= {quo_reg[g][NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg[g+1] <= (DEN_W+1)'(rem_sh);
                    quo_reg[g+1] <= {quo_reg[g][NUM_W-2:0], 1'b0};
                end
                den_reg[g+1] <= den_reg[g];
                neg_reg[g+1] <= neg_reg[g];
                tag_reg[g+1] <= tag_reg[g];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign out_quo   = neg_reg[NUM_W] ? -$signed({1'b0, quo_reg[NUM_W]})
                                      : $signed({1'b0, quo_reg[NUM_W]});
    assign out_tag   = tag_reg[NUM_W];

endmodule
